FILE: hw/rtl/ttr_pkg.sv
// Shared types and constants of the time-triggered task release block.
package ttr_pkg;

    localparam int TASK_INDEX_W = 3;
    localparam int TICKS_W      = 32;

    // Input item function codes
    localparam logic FUNC_REGISTER = 1'b0;
    localparam logic FUNC_TICK     = 1'b1;

    typedef logic [TASK_INDEX_W-1:0] task_index_t;
    typedef logic [TICKS_W-1:0]      ticks_t;

    // One result item
    typedef struct packed {
        task_index_t task_index;
        logic        released;
        logic        table_full;
        logic        last;
    } result_t;

endpackage

FILE: hw/rtl/ttr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ttr_ram #(
    parameter  int WIDTH  = 64,
    parameter  int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, register the read word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/time_triggered_task_release.sv
// Top level of the time-triggered task release block.
//
// Usage: s_ carries items in; func 0 registers a task (period, offset) in the
// next free slot, func 1 is one scheduler tick. m_ carries result items out.
// A registration gives one result: the new slot index, or table_full when
// every slot is taken. A tick walks the occupied slots in index order and
// gives one result per released task (released = 1), the final one marked
// last; a tick that releases nothing gives one empty result with last = 1.
// A registration's result passes the result register, then the output
// register. A tick does one read-modify-write per registered task on the
// task table RAM (read, then check and write back). One item is worked on
// at a time; s_ready is high while idle, even when the last result still
// sits in the output register.
// Reset clears the task count and all control state; the table needs no
// clearing since only registered slots are read. When the receiver stalls,
// the output register holds its transfer and the table walk pauses before
// it would produce the next result.
module time_triggered_task_release #(
    parameter int MAX_TASKS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  ttr_pkg::ticks_t      s_period_ticks,
    input  ttr_pkg::ticks_t      s_offset_ticks,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ttr_pkg::task_index_t m_task_index,
    output logic                 m_released,
    output logic                 m_table_full,
    output logic                 m_last
);
    import ttr_pkg::*;

    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int ENTRY_W = 2 * TICKS_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_valid_reg, pend_valid_next;
    task_index_t      pend_idx_reg, pend_idx_next;
    result_t          res_reg, res_next;
    result_t          out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    logic   s_xfer;
    logic   out_free;
    logic   table_full;
    ticks_t cur_period;
    ticks_t cur_delay;
    logic   due;
    ticks_t new_delay;

    // Task table: period in the upper half, delay in the lower half
    ttr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_xfer     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign table_full = (count_reg >= CNT_W'(MAX_TASKS));

    // Release check and reload of the entry just read
    assign cur_period = rd_data[ENTRY_W-1:TICKS_W];
    assign cur_delay  = rd_data[TICKS_W-1:0];
    assign due        = (cur_delay == '0);
    assign new_delay  = (due ? cur_period : cur_delay) - TICKS_W'(1);

    // Sequence control, table writes and output loading
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = {cur_period, new_delay};

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_func == FUNC_TICK) begin
                        idx_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_READ;
                    end else if (table_full) begin
                        res_next   = '{task_index: '0, released: 1'b0,
                                       table_full: 1'b1, last: 1'b1};
                        state_next = ST_EMIT;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        wr_data    = {s_period_ticks, s_offset_ticks};
                        count_next = count_reg + CNT_W'(1);
                        res_next   = '{task_index: TASK_INDEX_W'(count_reg),
                                       released: 1'b0, table_full: 1'b0,
                                       last: 1'b1};
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_READ: begin
                // Finish the walk, or go on to the check step while the entry is read
                if (idx_reg >= count_reg) begin
                    if (pend_valid_reg) begin
                        res_next = '{task_index: pend_idx_reg, released: 1'b1,
                                     table_full: 1'b0, last: 1'b1};
                    end else begin
                        res_next = '{task_index: '0, released: 1'b0,
                                     table_full: 1'b0, last: 1'b1};
                    end
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                // Hold while an earlier release cannot be handed on
                if (!(due && pend_valid_reg && !out_free)) begin
                    wr_en    = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                    if (due) begin
                        if (pend_valid_reg) begin
                            out_next     = '{task_index: pend_idx_reg, released: 1'b1,
                                             table_full: 1'b0, last: 1'b0};
                            m_valid_next = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = TASK_INDEX_W'(idx_reg);
                    end
                    state_next = ST_READ;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_task_index = out_reg.task_index;
    assign m_released   = out_reg.released;
    assign m_table_full = out_reg.table_full;
    assign m_last       = out_reg.last;

    // Task count never passes the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count above table depth");

    // An accepted registration into a free slot advances the count by one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_func == FUNC_REGISTER && !table_full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("registration did not advance task count");

    // The walk index never runs past the occupied slots
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ || state_reg == ST_CHK) |-> idx_reg <= count_reg)
        else $error("walk index beyond occupied slots");

    // A table write outside idle only happens during the check step
    a_wr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && state_reg != ST_IDLE) |-> state_reg == ST_CHK && idx_reg < count_reg)
        else $error("table write outside the check step");

    // A release result never reports a full table
    a_rel_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_released) |-> !m_table_full)
        else $error("release result flagged table full");

endmodule

FILE: tb/tb_time_triggered_task_release.sv
// Testbench for the time-triggered task release block.
`timescale 1ns / 100ps

module tb_time_triggered_task_release;

    import ttr_pkg::*;

    localparam int MAX_TASKS     = 8;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int DRAIN_CYCLES  = 2 * MAX_TASKS + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 70;
    localparam int TICK_PCT      = 85;

    // Fixed results that need no prediction
    localparam result_t NOTHING_RELEASED  = '{3'd0, 1'b0, 1'b0, 1'b1};
    localparam result_t TABLE_FULL_RESULT = '{3'd0, 1'b0, 1'b1, 1'b1};

    typedef struct packed {
        logic    func;
        ticks_t  period;
        ticks_t  offset;
        logic    typed;
        result_t want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 21;

    // Directed stimulus: empty tick, fill all slots (all due on the first tick),
    // two refused registrations, then ticks against the predictor.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{FUNC_TICK,     32'd0,          32'd0,          1'b1, NOTHING_RELEASED},
        '{FUNC_REGISTER, 32'd0,          32'd0,          1'b1, '{3'd0, 1'b0, 1'b0, 1'b1}},
        '{FUNC_REGISTER, 32'd1,          32'd0,          1'b1, '{3'd1, 1'b0, 1'b0, 1'b1}},
        '{FUNC_REGISTER, 32'hFFFF_FFFF,  32'd0,          1'b1, '{3'd2, 1'b0, 1'b0, 1'b1}},
        '{FUNC_REGISTER, 32'd2,          32'd0,          1'b1, '{3'd3, 1'b0, 1'b0, 1'b1}},
        '{FUNC_REGISTER, 32'd3,          32'd0,          1'b1, '{3'd4, 1'b0, 1'b0, 1'b1}},
        '{FUNC_REGISTER, 32'd5,          32'd0,          1'b1, '{3'd5, 1'b0, 1'b0, 1'b1}},
        '{FUNC_REGISTER, 32'd4,          32'd0,          1'b1, '{3'd6, 1'b0, 1'b0, 1'b1}},
        '{FUNC_REGISTER, 32'd6,          32'd0,          1'b1, '{3'd7, 1'b0, 1'b0, 1'b1}},
        '{FUNC_REGISTER, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, TABLE_FULL_RESULT},
        '{FUNC_REGISTER, 32'd0,          32'd0,          1'b1, TABLE_FULL_RESULT},
        '{FUNC_TICK,     32'd0,          32'd0,          1'b0, '0},
        '{FUNC_TICK,     32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, '0},
        '{FUNC_TICK,     32'd0,          32'd0,          1'b0, '0},
        '{FUNC_TICK,     32'd0,          32'd0,          1'b0, '0},
        '{FUNC_TICK,     32'd0,          32'd0,          1'b0, '0},
        '{FUNC_TICK,     32'd0,          32'd0,          1'b0, '0},
        '{FUNC_TICK,     32'd0,          32'd0,          1'b0, '0},
        '{FUNC_TICK,     32'd0,          32'd0,          1'b0, '0},
        '{FUNC_TICK,     32'd0,          32'd0,          1'b0, '0},
        '{FUNC_TICK,     32'd0,          32'd0,          1'b0, '0}
    };

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_func          = FUNC_REGISTER;
    ticks_t      s_period_ticks  = '0;
    ticks_t      s_offset_ticks  = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    task_index_t m_task_index;
    logic        m_released;
    logic        m_table_full;
    logic        m_last;

    // Typed expectation that travels with the item on the input
    logic        row_typed       = 1'b0;
    result_t     row_want        = '0;

    int          idle_pct        = 0;
    int          stall_pct       = 0;
    int          error_count     = 0;
    int          cycle_count     = 0;

    // Scheduler state as seen by the predictor
    int          task_count      = 0;
    ticks_t      slot_period [MAX_TASKS];
    ticks_t      slot_delay  [MAX_TASKS];
    result_t     pending_results [$];

    time_triggered_task_release #(
        .MAX_TASKS (MAX_TASKS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_period_ticks (s_period_ticks),
        .s_offset_ticks (s_offset_ticks),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_task_index   (m_task_index),
        .m_released     (m_released),
        .m_table_full   (m_table_full),
        .m_last         (m_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Apply one item to the task table and list the results it causes
    function automatic int schedule_item(input logic func, input ticks_t period,
                                         input ticks_t offset,
                                         output result_t res [MAX_TASKS]);
        int n = 0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            res[i] = '0;
        end
        if (func == FUNC_REGISTER) begin
            if (task_count >= MAX_TASKS) begin
                res[0] = TABLE_FULL_RESULT;
            end else begin
                slot_period[task_count] = period;
                slot_delay[task_count]  = offset;
                res[0] = '{task_index_t'(task_count), 1'b0, 1'b0, 1'b1};
                task_count++;
            end
            return 1;
        end
        // Release due tasks in index order, count down the rest
        for (int i = 0; i < task_count; i++) begin
            if (slot_delay[i] == '0) begin
                slot_delay[i] = slot_period[i] - 1'b1;
                res[n] = '{task_index_t'(i), 1'b1, 1'b0, 1'b0};
                n++;
            end else begin
                slot_delay[i] = slot_delay[i] - 1'b1;
            end
        end
        if (n == 0) begin
            res[0] = NOTHING_RELEASED;
            return 1;
        end
        res[n-1].last = 1'b1;
        return n;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Check each result transfer, then predict each accepted input transfer
    always @(posedge aclk) begin : monitor
        result_t want_r;
        result_t batch [MAX_TASKS];
        int      n;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: task_index %0d released %0d",
                           m_task_index, m_released);
                    error_count++;
                end else begin
                    want_r = pending_results.pop_front();
                    compare_field("task_index", want_r.task_index, m_task_index);
                    compare_field("released", want_r.released, m_released);
                    compare_field("table_full", want_r.table_full, m_table_full);
                    compare_field("last", want_r.last, m_last);
                end
            end
            if (s_valid && s_ready) begin
                n = schedule_item(s_func, s_period_ticks, s_offset_ticks, batch);
                if (row_typed) begin
                    pending_results.push_back(row_want);
                end else begin
                    for (int k = 0; k < n; k++) begin
                        pending_results.push_back(batch[k]);
                    end
                end
            end
        end
    end

    // Stall the receiver at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_time_triggered_task_release: errors");
            $finish;
        end
    end

    // Idle at random, then hold the item until its transfer; returns at a falling edge
    task automatic send_item(input logic func, input ticks_t period, input ticks_t offset,
                             input logic typed, input result_t want);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_period_ticks <= period;
        s_offset_ticks <= offset;
        row_typed      <= typed;
        row_want       <= want;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Favor the extremes of a tick count
    function automatic ticks_t random_ticks();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return ticks_t'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int phase_idle  [4] = '{0, 81, 0, 8};
        int phase_stall [4] = '{0, 0, 81, 8};
        logic func;

        // Hold reset, release it away from the sampling edge
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIRECTED[r]) begin
            send_item(DIRECTED[r].func, DIRECTED[r].period, DIRECTED[r].offset,
                      DIRECTED[r].typed, DIRECTED[r].want);
        end

        // Random part: mostly ticks, the rest refused registrations
        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            repeat (PHASE_ITEMS) begin
                func = ($urandom_range(0, 99) < TICK_PCT) ? FUNC_TICK : FUNC_REGISTER;
                send_item(func, random_ticks(), random_ticks(), 1'b0, '0);
            end
        end

        // Drain outstanding results, then allow for a stray one
        s_valid   <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb_time_triggered_task_release: clean");
        end else begin
            $display("tb_time_triggered_task_release: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ttr_pkg.sv
hw/rtl/ttr_ram.sv
hw/rtl/time_triggered_task_release.sv
tb/tb_time_triggered_task_release.sv
